### src/cli_pkg.sv
// cli_pkg: constants, state type and command codes for the cubic Lagrange
// interpolator. No dependencies; used by cubic_lagrange_interpolator.
`timescale 1ns / 1ps

package cli_pkg;

  // Sample store and field widths
  localparam int DEPTH       = 1024;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int POS_W       = 10;

  // Weight datapath
  localparam int FAC_W   = 18;                    // one unsigned polynomial factor
  localparam int MUL_A_W = 36;                    // shared multiplier, operand A
  localparam int MUL_B_W = 25;                    // shared multiplier, operand B
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int WGT_W   = 32;                    // signed Q.30 weight
  localparam int WGT_SH  = 19;                    // P / 2^19 gives the Q.30 weight
  localparam int WSUM_W  = WGT_W + WGT_SH;
  localparam int ACC_W   = 58;
  localparam int OUT_SH  = 30;
  localparam int Y_W     = ACC_W - OUT_SH;

  // Constants for the exact divide by three of one factor
  localparam logic [FAC_W-1:0] RECIP3    = FAC_W'(43691);  // (2^17 + 1) / 3
  localparam int               RECIP3_SH = 17;
  localparam logic [FAC_W-1:0] T_ONE     = FAC_W'(65536);
  localparam logic [FAC_W-1:0] T_TWO     = FAC_W'(131072);
  localparam logic [FAC_W-1:0] B3_BASE   = FAC_W'(21845);  // (T - 1) / 3
  localparam logic [FAC_W-1:0] C3_BASE   = FAC_W'(43690);  // (2T - 2) / 3
  localparam logic [FAC_W-1:0] D3_BASE   = FAC_W'(21846);  // (T + 2) / 3

  localparam logic [WSUM_W-1:0] WGT_HALF = WSUM_W'(1) << (WGT_SH - 1);
  localparam logic [ACC_W-1:0]  OUT_HALF = ACC_W'(1) << (OUT_SH - 1);

  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-(2**(SAMPLE_BITS-1)));

  // Request command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_INTERP = 1'b1;

  // Fraction residue mod 3: selects which factor carries the divide by three
  localparam logic [1:0] RES_0 = 2'd0;
  localparam logic [1:0] RES_1 = 2'd1;
  localparam logic [1:0] RES_2 = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV3,
    ST_QR,
    ST_PA,
    ST_PB,
    ST_CV,
    ST_MAC,
    ST_SUM,
    ST_RND
  } cli_state_t;

endpackage

### src/cli_ram.sv
// cli_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cli_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/cubic_lagrange_interpolator.sv
// cubic_lagrange_interpolator: sample store plus four-point cubic Lagrange
// interpolation. Depends on cli_pkg and cli_ram.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. A write request
// (cmd 0) stores write_sample at write_addr in that same cycle, gives no
// result and leaves busy low. An interpolate request (cmd 1) whose position
// is out of range (read_pos below 1 or above DEPTH-3) returns interp_value 0
// with range_error set on done in the next cycle, also without raising busy.
// An in-range interpolate request holds busy high up to and including ST_RND,
// and its result is registered onto done from ST_RND: one multiplier is
// shared by all 13 products (one divide-by-three, two per weight for four
// weights, four sample-weight products), with a step each for the
// remainder, the four weight roundings, the last accumulate and the output
// rounding. done is high for exactly one cycle and cannot be held off; the
// four samples read must have been written since reset.

module cubic_lagrange_interpolator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    cmd,
  input  logic [cli_pkg::ADDR_W-1:0]              write_addr,
  input  logic signed [cli_pkg::SAMPLE_BITS-1:0]  write_sample,
  input  logic [cli_pkg::POS_W-1:0]               read_pos,
  input  logic [cli_pkg::FRAC_BITS-1:0]           read_frac,
  output logic                                    done,
  output logic signed [cli_pkg::SAMPLE_BITS-1:0]  interp_value,
  output logic                                    clipped,
  output logic                                    range_error
);

  import cli_pkg::*;

  cli_state_t state, state_next;
  logic [1:0] idx;

  logic [POS_W-1:0]     pos;
  logic [FRAC_BITS-1:0] t;
  logic [FRAC_BITS-1:0] q;
  logic [1:0]           rsd;

  logic signed [WGT_W-1:0]       wgt [4];
  logic signed [SAMPLE_BITS-1:0] smp [4];
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;

  logic accept, in_range;
  logic [FAC_W-1:0] fb, fc, fd, fq, ft, q3b, q3c, q3d;
  logic [FAC_W-1:0] f1, f2, f3;
  logic             neg;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_res;

  logic [FRAC_BITS-1:0] qn;
  logic [WSUM_W-1:0]    pmag, psgn, psum;
  logic [ACC_W-1:0]     rsum;
  logic signed [Y_W-1:0] yv;

  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_raddr;
  logic signed [SAMPLE_BITS-1:0] ram_rdata;

  // request handshake and position check
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (read_pos != '0) && (read_pos <= POS_W'(DEPTH - 3));
  assign ram_we   = accept && (cmd == CMD_WRITE);

  // sample store
  cli_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_addr),
    .wdata (write_sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // polynomial factors: t, T-t, 2T-t, T+t and the divided-by-three forms
  assign ft  = FAC_W'(t);
  assign fq  = FAC_W'(q);
  assign fb  = T_ONE - ft;
  assign fc  = T_TWO - ft;
  assign fd  = T_ONE + ft;
  assign q3b = B3_BASE - fq;
  assign q3c = C3_BASE - fq;
  assign q3d = D3_BASE + fq;

  // factor choice per weight; the factor divisible by three follows t mod 3
  always_comb begin
    f1  = ft;
    f2  = fb;
    f3  = fc;
    neg = 1'b0;
    unique case (idx)
      2'd0: begin
        neg = 1'b1;
        case (rsd)
          RES_0:   begin f1 = fq; f2 = fb;  f3 = fc;  end
          RES_1:   begin f1 = ft; f2 = q3b; f3 = fc;  end
          default: begin f1 = ft; f2 = fb;  f3 = q3c; end
        endcase
      end
      2'd1: begin f1 = fb; f2 = fc; f3 = fd; end
      2'd2: begin f1 = ft; f2 = fc; f3 = fd; end
      default: begin
        neg = 1'b1;
        case (rsd)
          RES_0:   begin f1 = fd;  f2 = fq; f3 = fb;  end
          RES_1:   begin f1 = fd;  f2 = ft; f3 = q3b; end
          default: begin f1 = q3d; f2 = ft; f3 = fb;  end
        endcase
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && (cmd == CMD_INTERP) && in_range) state_next = ST_DIV3;
      ST_DIV3: state_next = ST_QR;
      ST_QR:   state_next = ST_PA;
      ST_PA:   state_next = ST_PB;
      ST_PB:   state_next = ST_CV;
      ST_CV:   state_next = (idx == 2'd3) ? ST_MAC : ST_PA;
      ST_MAC:  state_next = (idx == 2'd3) ? ST_SUM : ST_MAC;
      ST_SUM:  state_next = ST_RND;
      ST_RND:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // shared multiplier operands and store read address
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    ram_raddr = pos - POS_W'(1) + POS_W'(idx);
    unique case (state)
      ST_DIV3: begin
        mul_a = MUL_A_W'(ft);
        mul_b = MUL_B_W'(RECIP3);
      end
      ST_PA: begin
        mul_a = MUL_A_W'(f1);
        mul_b = MUL_B_W'(f2);
      end
      ST_PB: begin
        mul_a = signed'({1'b0, prod[MUL_A_W-2:0]});
        mul_b = MUL_B_W'(f3);
      end
      ST_MAC: begin
        mul_a = MUL_A_W'(wgt[idx]);
        mul_b = MUL_B_W'(smp[idx]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // quotient of t / 3, weight rounding and output rounding
  assign qn   = prod[RECIP3_SH +: FRAC_BITS];
  assign pmag = prod[WSUM_W-1:0];
  assign psgn = neg ? (-pmag) : pmag;
  assign psum = psgn + WGT_HALF;
  assign rsum = acc + OUT_HALF;
  assign yv   = signed'(rsum[ACC_W-1:OUT_SH]);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_RND) ||
               (accept && (cmd == CMD_INTERP) && !in_range);
      if (state == ST_QR) begin
        idx <= '0;
      end else if ((state == ST_CV) || (state == ST_MAC)) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_res;
    if (accept) begin
      pos <= read_pos;
      t   <= read_frac;
    end
    if (state == ST_QR) begin
      q   <= qn;
      rsd <= t[1:0] - qn[1:0] - {qn[0], 1'b0};
      acc <= '0;
    end
    if (state == ST_PB) begin
      smp[idx] <= ram_rdata;
    end
    if (state == ST_CV) begin
      wgt[idx] <= signed'(psum[WSUM_W-1:WGT_SH]);
    end
    if (((state == ST_MAC) && (idx != 2'd0)) || (state == ST_SUM)) begin
      acc <= acc + ACC_W'(prod);
    end
    // result: saturated value, or zero with the range flag
    if (state == ST_RND) begin
      range_error <= 1'b0;
      if (yv > Y_MAX) begin
        interp_value <= SAMPLE_BITS'(Y_MAX);
        clipped      <= 1'b1;
      end else if (yv < Y_MIN) begin
        interp_value <= SAMPLE_BITS'(Y_MIN);
        clipped      <= 1'b1;
      end else begin
        interp_value <= SAMPLE_BITS'(yv);
        clipped      <= 1'b0;
      end
    end else if (accept && (cmd == CMD_INTERP) && !in_range) begin
      interp_value <= '0;
      clipped      <= 1'b0;
      range_error  <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // a result only shows once the sequencer is back in idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a range error result carries a zero value and no clip
  assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> ((interp_value == '0) && !clipped))
    else $error("range error result not zero");

  // an in-range interpolate request starts the sequencer
  assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_INTERP) && in_range) |=> (busy && !done))
    else $error("interpolate request did not start");

  // a write request never produces a result
  assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_WRITE)) |=> !done)
    else $error("write request produced a result");
`endif

endmodule

### verif/tb_cubic_lagrange_interpolator.sv
// tb_cubic_lagrange_interpolator: self-checking testbench for the cubic Lagrange
// interpolator; mirrors the sample store and predicts every interpolation.
// Depends on cli_pkg and cubic_lagrange_interpolator.
`timescale 1ns / 1ps

module tb_cubic_lagrange_interpolator;
  import cli_pkg::*;

  localparam int     HALF_PERIOD  = 10;
  localparam int     STALL_LIMIT  = 2000;
  localparam int     DRAIN_CYCLES = 30;
  localparam int     MAX_REPORTS  = 10;
  localparam int     IDLE_PCT     = 26;
  localparam int     POS_MIN      = 1;
  localparam int     POS_MAX      = DEPTH - 3;
  localparam int     ROUND_SH     = 30;
  localparam longint FRAC_ONE     = longint'(65536);
  localparam longint WEIGHT_DIV   = longint'(6) << 18;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [FRAC_BITS-1:0]          F_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          clip;
    logic                          range_err;
  } interp_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          cmd = CMD_WRITE;
  logic [ADDR_W-1:0]             write_addr = '0;
  logic signed [SAMPLE_BITS-1:0] write_sample = '0;
  logic [POS_W-1:0]              read_pos = '0;
  logic [FRAC_BITS-1:0]          read_frac = '0;
  logic                          done;
  logic signed [SAMPLE_BITS-1:0] interp_value;
  logic                          clipped;
  logic                          range_error;

  // Mirror of the sample store and the results still owed by the block
  logic signed [SAMPLE_BITS-1:0] sample_mirror [DEPTH];
  bit                            sample_written [DEPTH];
  interp_result_t                pending_results [$];

  int error_count   = 0;
  int request_count = 0;
  int idle_pct      = IDLE_PCT;
  int idle_cycles   = 0;

  cubic_lagrange_interpolator u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .write_addr   (write_addr),
    .write_sample (write_sample),
    .read_pos     (read_pos),
    .read_frac    (read_frac),
    .done         (done),
    .interp_value (interp_value),
    .clipped      (clipped),
    .range_error  (range_error)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Division rounding toward minus infinity
  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // Scaled exact weight (times 6*T^3) to Q.30, round half up
  function automatic longint lagrange_weight(input longint scaled);
    return floor_div(scaled + WEIGHT_DIV / 2, WEIGHT_DIV);
  endfunction

  function automatic interp_result_t predict_interp(input logic [POS_W-1:0] pos,
                                                    input logic [FRAC_BITS-1:0] frac);
    interp_result_t res;
    longint         t;
    longint         acc;
    longint         y;
    longint         w [4];
    int             p;
    int             k;
    p = int'(pos);
    res.value     = '0;
    res.clip      = 1'b0;
    res.range_err = 1'b0;
    if (p < POS_MIN || p > POS_MAX) begin
      res.range_err = 1'b1;
      return res;
    end
    t = longint'(frac);
    w[0] = lagrange_weight(-(t * (t - FRAC_ONE) * (t - 2 * FRAC_ONE)));
    w[1] = lagrange_weight(3 * (t + FRAC_ONE) * (t - FRAC_ONE) * (t - 2 * FRAC_ONE));
    w[2] = lagrange_weight(-3 * (t + FRAC_ONE) * t * (t - 2 * FRAC_ONE));
    w[3] = lagrange_weight((t + FRAC_ONE) * t * (t - FRAC_ONE));
    acc = 0;
    for (k = 0; k < 4; k++) acc += longint'(sample_mirror[p - 1 + k]) * w[k];
    // arithmetic shift floors, so adding half rounds half up
    y = (acc + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
    if (y > longint'(S_MAX)) begin
      y        = longint'(S_MAX);
      res.clip = 1'b1;
    end else if (y < longint'(S_MIN)) begin
      y        = longint'(S_MIN);
      res.clip = 1'b1;
    end
    res.value = SAMPLE_BITS'(y);
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_BITS-1:0] random_frac();
    int pick;
    pick = $urandom_range(19);
    case (pick)
      0:       return '0;
      1:       return FRAC_BITS'(1);
      2:       return F_HALF;
      3:       return '1;
      default: return FRAC_BITS'($urandom);
    endcase
  endfunction

  // Send one request; start stays high afterwards so the next one can follow
  // back to back. The prediction is made at the edge that accepts it.
  task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic signed [SAMPLE_BITS-1:0] sample,
                              input logic [POS_W-1:0] pos,
                              input logic [FRAC_BITS-1:0] frac);
    int gap;
    // each cycle idles with the set chance
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd          <= op;
    write_addr   <= addr;
    write_sample <= sample;
    read_pos     <= pos;
    read_frac    <= frac;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    request_count++;
    if (op == CMD_WRITE) begin
      sample_mirror[addr]  = sample;
      sample_written[addr] = 1'b1;
    end else begin
      pending_results.push_back(predict_interp(pos, frac));
    end
  endtask

  // Write any sample of the four-point window that was never stored
  task automatic fill_window(input int p);
    int a;
    for (a = p - 1; a <= p + 2; a++) begin
      if (!sample_written[a])
        send_request(CMD_WRITE, ADDR_W'(a), random_sample(), POS_W'($urandom),
                     FRAC_BITS'($urandom));
    end
  endtask

  task automatic random_request();
    int                   roll;
    int                   p;
    logic [FRAC_BITS-1:0] frac;
    roll = $urandom_range(99);
    frac = random_frac();
    if (roll < 30) begin
      send_request(CMD_WRITE, ADDR_W'($urandom), random_sample(), POS_W'($urandom), frac);
    end else if (roll < 36) begin
      p = ($urandom_range(2) == 0) ? 0 : $urandom_range(DEPTH - 1, POS_MAX + 1);
      send_request(CMD_INTERP, ADDR_W'($urandom), SAMPLE_BITS'($urandom), POS_W'(p), frac);
    end else begin
      p = $urandom_range(POS_MAX, POS_MIN);
      fill_window(p);
      send_request(CMD_INTERP, ADDR_W'($urandom), SAMPLE_BITS'($urandom), POS_W'(p), frac);
    end
  endtask

  // Positions at zero and above the highest valid position
  task automatic test_range_errors();
    send_request(CMD_INTERP, '1, S_MIN, POS_W'(0), '0);
    send_request(CMD_INTERP, '0, S_MAX, POS_W'(POS_MAX + 1), '1);
    send_request(CMD_INTERP, '1, '1, POS_W'(DEPTH - 1), F_HALF);
  endtask

  // Full-scale samples in a min, max, max, min pattern and its inverse overshoot at mid fraction
  task automatic test_clipping();
    send_request(CMD_WRITE, ADDR_W'(1), S_MIN, '0, '0);
    send_request(CMD_WRITE, ADDR_W'(2), S_MAX, '0, '0);
    send_request(CMD_WRITE, ADDR_W'(3), S_MAX, '0, '0);
    send_request(CMD_WRITE, ADDR_W'(4), S_MIN, '0, '0);
    send_request(CMD_INTERP, '0, '0, POS_W'(2), F_HALF);
    send_request(CMD_WRITE, ADDR_W'(5), S_MAX, '1, '1);
    send_request(CMD_WRITE, ADDR_W'(6), S_MIN, '1, '1);
    send_request(CMD_WRITE, ADDR_W'(7), S_MIN, '1, '1);
    send_request(CMD_WRITE, ADDR_W'(8), S_MAX, '1, '1);
    send_request(CMD_INTERP, '1, '1, POS_W'(6), F_HALF);
  endtask

  // Lowest and highest valid positions, fraction extremes
  task automatic test_store_edges();
    send_request(CMD_WRITE, ADDR_W'(0), S_MIN, '0, '0);
    send_request(CMD_INTERP, '0, '0, POS_W'(POS_MIN), '0);
    send_request(CMD_INTERP, '0, '0, POS_W'(POS_MIN), '1);
    send_request(CMD_WRITE, ADDR_W'(DEPTH - 4), S_MAX, '0, '0);
    send_request(CMD_WRITE, ADDR_W'(DEPTH - 3), S_MIN, '0, '0);
    send_request(CMD_WRITE, ADDR_W'(DEPTH - 2), '0, '0, '0);
    send_request(CMD_WRITE, ADDR_W'(DEPTH - 1), '1, '0, '0);
    send_request(CMD_INTERP, '0, '0, POS_W'(POS_MAX), '0);
    send_request(CMD_INTERP, '0, '0, POS_W'(POS_MAX), FRAC_BITS'(1));
  endtask

  task automatic test_random_traffic(input int count);
    int target;
    target = request_count + count;
    while (request_count < target) random_request();
  endtask

  // Same mix with the sender never pausing
  task automatic test_back_to_back(input int count);
    idle_pct = 0;
    test_random_traffic(count);
    idle_pct = IDLE_PCT;
  endtask

  // Result check against the oldest prediction
  always @(posedge clk) begin : result_check
    interp_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: value %0d clipped %b range_error %b",
                   interp_value, clipped, range_error);
      end else begin
        exp_res = pending_results.pop_front();
        if (interp_value !== exp_res.value || clipped !== exp_res.clip ||
            range_error !== exp_res.range_err) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected value %0d clipped %b range_error %b, got %0d %b %b",
                     exp_res.value, exp_res.clip, exp_res.range_err,
                     interp_value, clipped, range_error);
        end
      end
    end
  end

  // Watchdog on cycles with neither a request nor a result taken
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_range_errors();
    test_clipping();
    test_store_edges();
    test_random_traffic(1400);
    test_back_to_back(220);
    @(negedge clk) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
